// File: design/lkv_pkg.sv
package lkv_pkg;

  localparam int unsigned MaxEntries = 16;
  localparam int unsigned KeyWidth   = 32;
  localparam int unsigned ValueWidth = 32;

  localparam int unsigned CapWidth = 5;
  localparam logic [CapWidth-1:0] CapReset = 5'd16;

  localparam logic OpGet = 1'b0;
  localparam logic OpPut = 1'b1;

  typedef struct packed {
    logic go;
    logic put;
    logic hit;
    logic evict;
  } ctrl_t;

endpackage

// File: design/lkv_req_if.sv
interface lkv_req_if #(
  parameter int unsigned KEY_WIDTH   = lkv_pkg::KeyWidth,
  parameter int unsigned VALUE_WIDTH = lkv_pkg::ValueWidth
);
  logic                   valid;
  logic                   ready;
  logic                   opcode;
  logic [KEY_WIDTH-1:0]   key;
  logic [VALUE_WIDTH-1:0] write_value;

  modport source (output valid, output opcode, output key, output write_value, input ready);
  modport sink   (input valid, input opcode, input key, input write_value, output ready);
endinterface

// File: design/lkv_rsp_if.sv
interface lkv_rsp_if #(
  parameter int unsigned KEY_WIDTH   = lkv_pkg::KeyWidth,
  parameter int unsigned VALUE_WIDTH = lkv_pkg::ValueWidth
);
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic [VALUE_WIDTH-1:0] read_value;
  logic                   evicted;
  logic [KEY_WIDTH-1:0]   evicted_key;

  modport source (output valid, output hit, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  input evicted_key, output ready);
endinterface

// File: design/lkv_cell.sv
module lkv_cell #(
  parameter int unsigned KEY_WIDTH   = lkv_pkg::KeyWidth,
  parameter int unsigned VALUE_WIDTH = lkv_pkg::ValueWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lkv_pkg::ctrl_t         ctrl_i,
  input  logic [KEY_WIDTH-1:0]   search_key_i,
  input  logic                   prev_valid_i,
  input  logic [KEY_WIDTH-1:0]   prev_key_i,
  input  logic [VALUE_WIDTH-1:0] prev_value_i,
  input  logic                   later_match_i,
  output logic                   valid_o,
  output logic [KEY_WIDTH-1:0]   key_o,
  output logic [VALUE_WIDTH-1:0] value_o,
  output logic                   match_o,
  output logic                   later_match_o
);

  logic                   valid_q, valid_d;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic                   match;
  logic                   shift;

  assign match = valid_q && (key_q == search_key_i);

  always_comb begin
    shift = 1'b0;
    if (ctrl_i.go) begin
      if (ctrl_i.hit) begin
        shift = match || later_match_i;
      end else if (ctrl_i.put) begin
        shift = ctrl_i.evict ? valid_q : 1'b1;
      end
    end
    valid_d = shift ? prev_valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      key_q   <= prev_key_i;
      value_q <= prev_value_i;
    end
  end

  assign valid_o       = valid_q;
  assign key_o         = key_q;
  assign value_o       = value_q;
  assign match_o       = match;
  assign later_match_o = match || later_match_i;

endmodule

// File: design/lru_key_value_cache_core.sv
// Fully associative key-value cache with least-recently-used replacement.
// Request channel req_i carries opcode (get or put), key and write_value;
// response channel rsp_o returns hit, read_value, evicted and evicted_key,
// one response per request, in request order.
// Entries sit in a row of cells ordered by recency, the most recent in
// cell 0. Every request compares its key against all cells at once and the
// cells ahead of the touched position pass their entries one place along.
// The response is registered and appears in the cycle after the transfer
// of its request. Throughput: one request per cycle while the receiver
// takes responses, set by the key compare and shift across the row.
// Capacity is written through cfg_we_i/cfg_wdata_i; the user must do so only while the
// cache is idle; the block does not enforce it. Zero acts as one, values above MAX_ENTRIES as MAX_ENTRIES.
// Reset empties the cache, sets capacity to 16 and drops any response held.
// While the receiver stalls, the held response stays put and a new request
// is taken only in the cycle the held response is transferred.
module lru_key_value_cache_core #(
  parameter int unsigned MAX_ENTRIES = lkv_pkg::MaxEntries,
  parameter int unsigned KEY_WIDTH   = lkv_pkg::KeyWidth,
  parameter int unsigned VALUE_WIDTH = lkv_pkg::ValueWidth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lkv_pkg::CapWidth-1:0]   cfg_wdata_i,
  lkv_req_if.sink                        req_i,
  lkv_rsp_if.source                      rsp_o
);

  localparam int unsigned OccWidth = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CmpWidth =
      (OccWidth > lkv_pkg::CapWidth) ? OccWidth : lkv_pkg::CapWidth;

  logic [lkv_pkg::CapWidth-1:0] cap_q;
  logic [OccWidth-1:0]          occ_q, occ_d;

  logic                   rsp_valid_q;
  logic                   rsp_hit_q;
  logic [VALUE_WIDTH-1:0] rsp_value_q;
  logic                   rsp_evicted_q;
  logic [KEY_WIDTH-1:0]   rsp_evkey_q;

  logic                   cell_valid [MAX_ENTRIES];
  logic [KEY_WIDTH-1:0]   cell_key   [MAX_ENTRIES];
  logic [VALUE_WIDTH-1:0] cell_value [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_match;
  logic                   later_match [MAX_ENTRIES+1];

  lkv_pkg::ctrl_t         ctrl;
  logic                   go;
  logic                   is_put;
  logic                   hit;
  logic                   full;
  logic [VALUE_WIDTH-1:0] hit_value;
  logic [KEY_WIDTH-1:0]   last_key;
  logic [VALUE_WIDTH-1:0] front_value;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign go          = req_i.valid && req_i.ready;
  assign is_put      = (req_i.opcode == lkv_pkg::OpPut);
  assign hit         = |cell_match;

  always_comb begin
    if (cap_q == '0) begin
      full = (occ_q != '0);
    end else begin
      full = (CmpWidth'(occ_q) >= CmpWidth'(cap_q)) ||
             (occ_q == OccWidth'(MAX_ENTRIES));
    end
  end

  always_comb begin
    ctrl.go    = go;
    ctrl.put   = is_put;
    ctrl.hit   = hit;
    ctrl.evict = is_put && !hit && full;
  end

  always_comb begin
    hit_value = '0;
    last_key  = '0;
    for (int unsigned i = 0; i < MAX_ENTRIES; i++) begin
      if (cell_match[i]) begin
        hit_value = hit_value | cell_value[i];
      end
      if (cell_valid[i] && ((i == MAX_ENTRIES - 1) || !cell_valid[(i+1) % MAX_ENTRIES])) begin
        last_key = last_key | cell_key[i];
      end
    end
  end

  assign front_value = is_put ? req_i.write_value : hit_value;

  assign later_match[MAX_ENTRIES] = 1'b0;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : gen_cell
    logic                   prev_valid;
    logic [KEY_WIDTH-1:0]   prev_key;
    logic [VALUE_WIDTH-1:0] prev_value;

    if (g == 0) begin : gen_front
      assign prev_valid = 1'b1;
      assign prev_key   = req_i.key;
      assign prev_value = front_value;
    end else begin : gen_link
      assign prev_valid = cell_valid[g-1];
      assign prev_key   = cell_key[g-1];
      assign prev_value = cell_value[g-1];
    end

    lkv_cell #(
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .search_key_i  (req_i.key),
      .prev_valid_i  (prev_valid),
      .prev_key_i    (prev_key),
      .prev_value_i  (prev_value),
      .later_match_i (later_match[g+1]),
      .valid_o       (cell_valid[g]),
      .key_o         (cell_key[g]),
      .value_o       (cell_value[g]),
      .match_o       (cell_match[g]),
      .later_match_o (later_match[g])
    );
  end

  always_comb begin
    occ_d = occ_q;
    if (go && is_put && !hit && !full) begin
      occ_d = occ_q + OccWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= lkv_pkg::CapReset;
      occ_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      occ_q <= occ_d;
      if (go) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      rsp_hit_q     <= hit;
      rsp_evicted_q <= ctrl.evict;
      rsp_evkey_q   <= ctrl.evict ? last_key : '0;
      if (is_put) begin
        rsp_value_q <= '0;
      end else begin
        rsp_value_q <= hit ? hit_value : '1;
      end
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.hit         = rsp_hit_q;
  assign rsp_o.read_value  = rsp_value_q;
  assign rsp_o.evicted     = rsp_evicted_q;
  assign rsp_o.evicted_key = rsp_evkey_q;

endmodule

// File: tb/lru_key_value_cache_core_tb.sv
module lru_key_value_cache_core_tb;

  localparam int unsigned CycleLimit = 300000;

  typedef struct packed {
    logic                           hit;
    logic [lkv_pkg::ValueWidth-1:0] read_value;
    logic                           evicted;
    logic [lkv_pkg::KeyWidth-1:0]   evicted_key;
  } cache_rsp_t;

  class cache_shadow;
    logic [lkv_pkg::KeyWidth-1:0]   keys[lkv_pkg::MaxEntries];
    logic [lkv_pkg::ValueWidth-1:0] vals[lkv_pkg::MaxEntries];
    bit                             live[lkv_pkg::MaxEntries];
    int unsigned                    age[lkv_pkg::MaxEntries];
    int unsigned                    occupancy;
    logic [lkv_pkg::CapWidth-1:0]   capacity;
    cache_rsp_t                     expected_rsp[$];
    int unsigned                    errors;

    function new();
      for (int i = 0; i < lkv_pkg::MaxEntries; i++) begin
        live[i] = 1'b0;
        age[i]  = 0;
      end
      occupancy = 0;
      capacity  = lkv_pkg::CapReset;
      errors    = 0;
    endfunction

    function void set_capacity(logic [lkv_pkg::CapWidth-1:0] cap);
      capacity = cap;
    endfunction

    function int unsigned outstanding();
      return expected_rsp.size();
    endfunction

    function int unsigned usable_slots();
      if (capacity == 0) return 1;
      if (capacity > lkv_pkg::MaxEntries) return lkv_pkg::MaxEntries;
      return capacity;
    endfunction

    function void promote(int s);
      int unsigned r0;
      r0 = age[s];
      for (int i = 0; i < lkv_pkg::MaxEntries; i++)
        if (live[i] && i != s && age[i] < r0) age[i]++;
      age[s] = 0;
    endfunction

    function void note_request(logic op, logic [lkv_pkg::KeyWidth-1:0] k,
                               logic [lkv_pkg::ValueWidth-1:0] v);
      int          found;
      int          slot;
      int unsigned best;
      cache_rsp_t  r;
      found = -1;
      slot  = -1;
      best  = 0;
      r     = '0;
      for (int i = 0; i < lkv_pkg::MaxEntries; i++)
        if (found < 0 && live[i] && keys[i] == k) found = i;
      if (op == lkv_pkg::OpGet) begin
        if (found >= 0) begin
          r.hit        = 1'b1;
          r.read_value = vals[found];
          promote(found);
        end else begin
          r.read_value = '1;
        end
      end else if (found >= 0) begin
        r.hit       = 1'b1;
        vals[found] = v;
        promote(found);
      end else begin
        if (occupancy >= usable_slots()) begin
          for (int i = 0; i < lkv_pkg::MaxEntries; i++)
            if (live[i] && (slot < 0 || age[i] > best)) begin
              slot = i;
              best = age[i];
            end
          if (slot >= 0) begin
            r.evicted     = 1'b1;
            r.evicted_key = keys[slot];
            live[slot]    = 1'b0;
          end
        end
        if (slot < 0) begin
          for (int i = 0; i < lkv_pkg::MaxEntries; i++)
            if (slot < 0 && !live[i]) slot = i;
          if (slot >= 0) occupancy++;
        end
        if (slot >= 0) begin
          keys[slot] = k;
          vals[slot] = v;
          for (int i = 0; i < lkv_pkg::MaxEntries; i++)
            if (live[i] && i != slot) age[i]++;
          live[slot] = 1'b1;
          age[slot]  = 0;
        end
      end
      expected_rsp.push_back(r);
    endfunction

    function void check_response(cache_rsp_t got);
      cache_rsp_t want;
      if (expected_rsp.size() == 0) begin
        $display("%0t: response with none outstanding, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_rsp.pop_front();
      if (got.hit !== want.hit) begin
        $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
        errors++;
      end
      if (got.read_value !== want.read_value) begin
        $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                 got.read_value);
        errors++;
      end
      if (got.evicted !== want.evicted) begin
        $display("%0t: evicted expected %0b actual %0b", $time, want.evicted, got.evicted);
        errors++;
      end
      if (got.evicted_key !== want.evicted_key) begin
        $display("%0t: evicted_key expected %h actual %h", $time, want.evicted_key,
                 got.evicted_key);
        errors++;
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [lkv_pkg::CapWidth-1:0] cfg_wdata_i;

  lkv_req_if req_if ();
  lkv_rsp_if rsp_if ();

  lru_key_value_cache_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  cache_shadow                  shadow;
  bit                           gaps_on = 1'b1;
  int unsigned                  stall_cycles = 0;
  int unsigned                  cycle_count = 0;
  logic [lkv_pkg::KeyWidth-1:0] key_pool[32];
  int unsigned                  pool_size = 1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("lru_key_value_cache_core: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      shadow.check_response({rsp_if.hit, rsp_if.read_value, rsp_if.evicted,
                             rsp_if.evicted_key});
  end

  initial begin
    int unsigned n;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_cycles > 0) begin
        n            = stall_cycles;
        stall_cycles = 0;
        rsp_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        rsp_if.ready <= !(gaps_on && $urandom_range(99) < 38);
      end
    end
  end

  task automatic send_request(input logic op, input logic [lkv_pkg::KeyWidth-1:0] k,
                              input logic [lkv_pkg::ValueWidth-1:0] v);
    while (gaps_on && $urandom_range(99) < 38) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.opcode      <= op;
    req_if.key         <= k;
    req_if.write_value <= v;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    shadow.note_request(op, k, v);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (shadow.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [lkv_pkg::CapWidth-1:0] cap);
    drain();
    repeat (2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    shadow.set_capacity(cap);
    cfg_we_i <= 1'b0;
  endtask

  task automatic refill_pool(input int unsigned size);
    pool_size = size;
    for (int i = 0; i < 32; i++) key_pool[i] = $urandom;
  endtask

  task automatic run_items(input int unsigned count);
    int unsigned                  pick;
    logic [lkv_pkg::KeyWidth-1:0] k;
    logic                         op;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      k    = key_pool[$urandom_range(pool_size - 1)];
      // random keys, or near misses: one bit away from a pool key
      if (pick >= 92) k = $urandom;
      else if (pick >= 85) k = k ^ (32'h1 << $urandom_range(lkv_pkg::KeyWidth - 1));
      op = ($urandom_range(99) < 50) ? lkv_pkg::OpPut : lkv_pkg::OpGet;
      send_request(op, k, $urandom);
    end
  endtask

  initial begin
    shadow = new();
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    req_if.valid       <= 1'b0;
    req_if.opcode      <= lkv_pkg::OpGet;
    req_if.key         <= '0;
    req_if.write_value <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(lkv_pkg::OpGet, 32'h0000_0000, 32'hffff_ffff);
    send_request(lkv_pkg::OpPut, 32'h8000_0000, 32'h7fff_ffff);
    send_request(lkv_pkg::OpPut, 32'h7fff_ffff, 32'h8000_0000);
    send_request(lkv_pkg::OpPut, 32'h0000_0000, 32'h0000_0000);
    send_request(lkv_pkg::OpPut, 32'hffff_ffff, 32'hffff_ffff);
    send_request(lkv_pkg::OpGet, 32'h8000_0000, 32'h0000_0000);
    send_request(lkv_pkg::OpGet, 32'h7fff_ffff, 32'h1234_5678);
    send_request(lkv_pkg::OpGet, 32'h0000_0000, 32'h0000_0000);
    send_request(lkv_pkg::OpGet, 32'hffff_ffff, 32'h0000_0000);
    send_request(lkv_pkg::OpGet, 32'h0000_0001, 32'h0000_0000);
    send_request(lkv_pkg::OpGet, 32'hffff_fffe, 32'h0000_0000);
    send_request(lkv_pkg::OpGet, 32'h7fff_fffe, 32'h0000_0000);
    send_request(lkv_pkg::OpGet, 32'h0000_8000, 32'h0000_0000);
    send_request(lkv_pkg::OpPut, 32'h7fff_ffff, 32'h0000_0001);
    send_request(lkv_pkg::OpGet, 32'h7fff_ffff, 32'hffff_ffff);
    send_request(lkv_pkg::OpPut, 32'h1234_5678, 32'ha5a5_a5a5);
    send_request(lkv_pkg::OpGet, 32'h1234_5678, 32'h5a5a_5a5a);
    send_request(lkv_pkg::OpPut, 32'h8000_0000, 32'h0000_0000);

    refill_pool(24);
    run_items(120);
    write_capacity(5'd3);
    run_items(110);
    write_capacity(5'd1);
    refill_pool(4);
    run_items(55);
    stall_cycles = 80;
    run_items(55);
    write_capacity(5'd0);
    run_items(100);
    write_capacity(5'd31);
    refill_pool(24);
    run_items(60);
    drain();
    run_items(60);
    write_capacity(5'd17);
    run_items(110);
    gaps_on = 1'b0;
    write_capacity(5'd8);
    refill_pool(12);
    run_items(200);
    gaps_on = 1'b1;
    write_capacity(5'd2);
    refill_pool(5);
    run_items(110);
    write_capacity(5'd16);
    refill_pool(20);
    run_items(120);

    drain();
    repeat (5) @(posedge clk_i);
    if (shadow.errors == 0) begin
      $display("lru_key_value_cache_core: match");
    end else begin
      $display("lru_key_value_cache_core: mismatch");
    end
    $finish;
  end

endmodule
